[rtl/lspp_pkg.sv]
// package for the line sensor packet parser: frame constants and shared types
package lspp_pkg;

    localparam int unsigned FRAME_LEN = 9;
    localparam logic [7:0] FRAME_HEADER = 8'hFF;
    localparam logic [7:0] FRAME_FOOTER = 8'hFE;
    localparam int unsigned CLEARED_BIT = 9;
    localparam logic [7:0] ONLINE_MASK = 8'h01;

    // byte position of the last frame byte, held by the counter when it arrives
    localparam logic [3:0] LAST_POS = 4'(FRAME_LEN - 1);
    localparam logic [3:0] END_POS = 4'(FRAME_LEN);

    // payload bytes 1 to 7 of a frame, index 0 is frame byte 1
    typedef logic [6:0][7:0] t_frame_data;

    // collector state seen by the top level
    typedef struct packed {
        logic       collecting;
        logic [3:0] byte_index;
        logic       completing;
    } t_coll_status;

    // decoded frame
    typedef struct packed {
        logic               good;
        logic               on_line;
        logic [15:0]        sensor_bits;
        logic signed [15:0] angle_tenths;
        logic [7:0]         confidence;
        logic               side_back;
        logic               side_left;
        logic               side_front;
        logic               side_right;
    } t_result;

endpackage

[rtl/lspp_collector.sv]
// frame collector: header hunt, byte counter and payload byte store
module lspp_collector (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_rx_byte,
    output lspp_pkg::t_coll_status o_status,
    output lspp_pkg::t_frame_data o_data
);

    logic       r_collecting;
    logic       n_collecting;
    logic [3:0] r_byte_index;
    logic [3:0] n_byte_index;
    logic [3:0] idx_inc;
    lspp_pkg::t_frame_data r_data;

    assign idx_inc = r_byte_index + 4'd1;

    always_comb begin
        n_collecting = r_collecting;
        n_byte_index = r_byte_index;
        if (i_accept) begin
            if (!r_collecting) begin
                if (i_rx_byte == lspp_pkg::FRAME_HEADER) begin
                    n_collecting = 1'b1;
                    n_byte_index = 4'd1;
                end
            end else if (r_byte_index < lspp_pkg::END_POS) begin
                if (idx_inc >= lspp_pkg::END_POS) begin
                    n_collecting = 1'b0;
                    n_byte_index = 4'd0;
                end else begin
                    n_byte_index = idx_inc;
                end
            end else begin
                // out of range count, drop back to header hunt
                n_collecting = 1'b0;
                n_byte_index = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collecting <= 1'b0;
            r_byte_index <= 4'd0;
        end else begin
            r_collecting <= n_collecting;
            r_byte_index <= n_byte_index;
        end
    end

    // payload store, bytes 1..7 only; header and footer are not kept
    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= 7; k++) begin
            if (i_accept && r_collecting && (r_byte_index == 4'(k))) begin
                r_data[k-1] <= i_rx_byte;
            end
        end
    end

    assign o_status.collecting = r_collecting;
    assign o_status.byte_index = r_byte_index;
    assign o_status.completing = r_collecting && (r_byte_index == lspp_pkg::LAST_POS);
    assign o_data = r_data;

endmodule

[rtl/lspp_decoder.sv]
// frame checker and field decoder: footer, xor checksum and field unpacking
module lspp_decoder (
    input  lspp_pkg::t_frame_data i_data,
    input  logic [7:0]            i_footer,
    output lspp_pkg::t_result     o_result
);

    logic [7:0]  sum;
    logic [15:0] bits;

    assign sum = i_data[0] ^ i_data[1] ^ i_data[2] ^ i_data[3] ^ i_data[4] ^ i_data[5];

    always_comb begin
        bits = {i_data[1], i_data[2]};
        bits[lspp_pkg::CLEARED_BIT] = 1'b0;
    end

    assign o_result.good = (i_footer == lspp_pkg::FRAME_FOOTER) && (sum == i_data[6]);
    assign o_result.on_line = |(i_data[0] & lspp_pkg::ONLINE_MASK);
    assign o_result.sensor_bits = bits;
    assign o_result.angle_tenths = $signed({i_data[3], i_data[4]});
    assign o_result.confidence = i_data[5];
    assign o_result.side_back = bits[12];
    assign o_result.side_left = bits[13];
    assign o_result.side_front = bits[14];
    assign o_result.side_right = bits[15];

endmodule

[rtl/line_sensor_packet_parser_unit.sv]
// top level of the line sensor packet parser: collector, decoder and result register
// output: a good frame's result appears in the cycle after the request carrying the footer byte
// throughput: one byte request per cycle; only the footer byte waits on a full,
//   stalled result register, every other byte is taken regardless
// reset: synchronous active low, returns to header hunt with an empty result register
module line_sensor_packet_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_on_line,
    output logic [15:0]        o_sensor_bits,
    output logic signed [15:0] o_angle_tenths,
    output logic [7:0]         o_confidence,
    output logic               o_side_back,
    output logic               o_side_left,
    output logic               o_side_front,
    output logic               o_side_right
);

    lspp_pkg::t_coll_status status;
    lspp_pkg::t_frame_data  frame_data;
    lspp_pkg::t_result      dec_result;

    logic in_accept;
    logic out_free;
    logic load;

    logic               r_out_valid;
    logic               n_out_valid;
    lspp_pkg::t_result  r_result;

    // result register can take a new request when empty or being drained
    assign out_free = !r_out_valid || i_out_ready;
    // only the byte that closes a frame can produce a result request
    assign o_in_ready = out_free || !status.completing;
    assign in_accept = i_in_valid && o_in_ready;

    lspp_collector u_collector (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_status  (status),
        .o_data    (frame_data)
    );

    // the incoming byte is checked as the footer while bytes 1..7 come from the store
    lspp_decoder u_decoder (
        .i_data   (frame_data),
        .i_footer (i_rx_byte),
        .o_result (dec_result)
    );

    // load a result on a good frame closing this cycle
    assign load = in_accept && status.completing && dec_result.good;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload needs no reset, qualified by r_out_valid
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= dec_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_on_line = r_result.on_line;
    assign o_sensor_bits = r_result.sensor_bits;
    assign o_angle_tenths = r_result.angle_tenths;
    assign o_confidence = r_result.confidence;
    assign o_side_back = r_result.side_back;
    assign o_side_left = r_result.side_left;
    assign o_side_front = r_result.side_front;
    assign o_side_right = r_result.side_right;

    // the counter stays inside the frame while collecting
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.collecting |-> (status.byte_index >= 4'd1) &&
                              (status.byte_index <= lspp_pkg::LAST_POS))
        else $error("byte index out of range while collecting");

    // header hunt always starts from a cleared counter
    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !status.collecting |-> (status.byte_index == 4'd0))
        else $error("byte index not cleared while idle");

    // closing byte always returns to header hunt
    a_close_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && status.completing) |=> !status.collecting)
        else $error("collector did not return to idle after frame end");

    // a stalled full result register blocks the closing byte only
    a_stall_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> (o_in_ready == !status.completing))
        else $error("input ready wrong while result is stalled");

endmodule

[tb/tb_line_sensor_packet_parser_unit.sv]
`timescale 1ns / 1ps
// self-checking testbench for the line sensor packet parser: byte streams in, decoded readings out
module tb_line_sensor_packet_parser_unit;

    // one decoded reading as the block presents it
    typedef struct packed {
        logic        on_line;
        logic [15:0] sensor_bits;
        logic [15:0] angle_tenths;
        logic [7:0]  confidence;
        logic        side_back;
        logic        side_left;
        logic        side_front;
        logic        side_right;
    } t_line_reading;

    // block ports, every input known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_on_line;
    logic [15:0]        o_sensor_bits;
    logic signed [15:0] o_angle_tenths;
    logic [7:0]         o_confidence;
    logic               o_side_back;
    logic               o_side_left;
    logic               o_side_front;
    logic               o_side_right;

    // serial bytes still to be offered, and readings the parser owes us
    logic [7:0]    byte_backlog[$];
    t_line_reading readings_due[$];

    int bytes_total = 0;
    int bytes_taken = 0;
    int stream_bytes = 0;
    int readings_seen = 0;
    int faults = 0;

    // last part of the run: no idling on either side
    bit drain_phase = 1'b0;

    // sender and receiver idle bookkeeping
    int gap_left = 0;
    int tx_calm_left = 0;
    int stall_left = 0;
    int rx_calm_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // shadow of the frame collector
    bit         in_frame = 1'b0;
    logic [3:0] frame_pos = 4'd0;
    logic [7:0] frame_buf [lspp_pkg::FRAME_LEN];

    line_sensor_packet_parser_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_on_line      (o_on_line),
        .o_sensor_bits  (o_sensor_bits),
        .o_angle_tenths (o_angle_tenths),
        .o_confidence   (o_confidence),
        .o_side_back    (o_side_back),
        .o_side_left    (o_side_left),
        .o_side_front   (o_side_front),
        .o_side_right   (o_side_right)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // reset held low from time zero, then released for good
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop in case the block hangs on a handshake
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // feed one accepted byte to the shadow collector; returns 1 when a good frame completes
    function automatic bit parse_byte(input logic [7:0] b, output t_line_reading r);
        logic [7:0]  sum;
        logic [15:0] bits;
        r = '0;
        // idle: hunt for the header, anything else is dropped
        if (!in_frame) begin
            if (b == lspp_pkg::FRAME_HEADER) begin
                frame_buf[0] = b;
                frame_pos = 4'd1;
                in_frame = 1'b1;
            end
            return 1'b0;
        end
        // inside a frame every byte is data, a header byte included
        frame_buf[frame_pos] = b;
        frame_pos = frame_pos + 4'd1;
        if (frame_pos != lspp_pkg::FRAME_LEN)
            return 1'b0;
        // ninth byte: back to hunting whatever the frame held
        in_frame = 1'b0;
        frame_pos = 4'd0;
        if (frame_buf[8] != lspp_pkg::FRAME_FOOTER)
            return 1'b0;
        sum = frame_buf[1] ^ frame_buf[2] ^ frame_buf[3] ^ frame_buf[4] ^ frame_buf[5] ^
              frame_buf[6];
        if (sum != frame_buf[7])
            return 1'b0;
        bits = {frame_buf[2], frame_buf[3]};
        bits[lspp_pkg::CLEARED_BIT] = 1'b0;
        r.on_line      = |(frame_buf[1] & lspp_pkg::ONLINE_MASK);
        r.sensor_bits  = bits;
        r.angle_tenths = {frame_buf[4], frame_buf[5]};
        r.confidence   = frame_buf[6];
        r.side_back    = bits[12];
        r.side_left    = bits[13];
        r.side_front   = bits[14];
        r.side_right   = bits[15];
        return 1'b1;
    endfunction

    function automatic string fmt_reading(input t_line_reading r);
        return $sformatf("on=%0b bits=%04h angle=%0d conf=%0d sides(b,l,f,r)=%0b%0b%0b%0b",
                         r.on_line, r.sensor_bits, $signed(r.angle_tenths), r.confidence,
                         r.side_back, r.side_left, r.side_front, r.side_right);
    endfunction

    // random byte leaning on the values the parser treats specially
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return lspp_pkg::FRAME_HEADER;
            2: return lspp_pkg::FRAME_FOOTER;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // queue a full nine byte frame; body holds bytes 1 to 6, byte 1 in the top octet;
    // chk_flip spoils the checksum when nonzero
    task automatic add_frame(input logic [47:0] body, input logic [7:0] chk_flip,
                             input logic [7:0] footer);
        logic [7:0] sum;
        logic [7:0] b;
        sum = chk_flip;
        byte_backlog.push_back(lspp_pkg::FRAME_HEADER);
        for (int k = 0; k < 6; k++) begin
            b = body[47 - 8 * k -: 8];
            sum = sum ^ b;
            byte_backlog.push_back(b);
        end
        byte_backlog.push_back(sum);
        byte_backlog.push_back(footer);
        stream_bytes += lspp_pkg::FRAME_LEN;
    endtask

    // stimulus: directed frames, then random frames with some noise and damage
    initial begin : stimulus
        int         kind;
        int         extra;
        logic [7:0] footer;
        // stray bytes while hunting are ignored
        byte_backlog.push_back(8'h00);
        byte_backlog.push_back(lspp_pkg::FRAME_FOOTER);
        stream_bytes += 2;
        // all-ones sensors, most negative angle, full confidence, header bytes as data
        add_frame(48'h01_FF_FF_80_00_FF, 8'h00, lspp_pkg::FRAME_FOOTER);
        // only bit 9 set (must read back zero), largest angle, zero confidence, off line
        add_frame(48'hFE_02_00_7F_FF_00, 8'h00, lspp_pkg::FRAME_FOOTER);
        // wrong footer, frame dropped
        add_frame(48'h00_00_00_00_00_00, 8'h00, 8'h00);
        // wrong checksum, frame dropped
        add_frame(48'h01_F0_00_FF_FF_80, 8'h01, lspp_pkg::FRAME_FOOTER);

        while (stream_bytes < 1950) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                add_frame({pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           pick_byte()}, 8'h00, lspp_pkg::FRAME_FOOTER);
            end else if (kind < 80) begin
                add_frame({pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           pick_byte()}, 8'($urandom_range(1, 255)), lspp_pkg::FRAME_FOOTER);
            end else if (kind < 88) begin
                footer = pick_byte();
                if (footer == lspp_pkg::FRAME_FOOTER)
                    footer = footer ^ 8'(1 << $urandom_range(0, 7));
                add_frame({pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                           pick_byte()}, 8'h00, footer);
            end else if (kind < 95) begin
                // cut-off frame: the following bytes get swallowed as its tail
                extra = $urandom_range(1, 7);
                byte_backlog.push_back(lspp_pkg::FRAME_HEADER);
                repeat (extra) byte_backlog.push_back(pick_byte());
                stream_bytes += 1 + extra;
            end else begin
                // line noise between frames
                extra = $urandom_range(1, 4);
                repeat (extra) byte_backlog.push_back(8'($urandom_range(0, 254)));
                stream_bytes += extra;
            end
        end
        bytes_total = byte_backlog.size();

        // wait for every request to go in and every reading to come out
        wait (i_rst_n);
        while (bytes_taken < bytes_total) @(posedge i_clk);
        while (readings_due.size() != 0) @(posedge i_clk);
        // the result is registered; keep the clock running to catch stray outputs
        repeat (16) @(posedge i_clk);
        if (faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // sender: one byte request at a time, held until taken
    always @(posedge i_clk) begin : byte_sender
        t_line_reading r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // request taken at this edge: run it through the shadow collector
            if (i_in_valid && o_in_ready) begin
                bytes_taken <= bytes_taken + 1;
                if (parse_byte(i_rx_byte, r))
                    readings_due.push_back(r);
            end
            // stretches with no idling now and then
            if (tx_calm_left > 0)
                tx_calm_left--;
            else if ($urandom_range(0, 63) == 0)
                tx_calm_left = $urandom_range(20, 60);
            // channel free for a new request after this edge
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (!drain_phase && tx_calm_left == 0 && $urandom_range(0, 5) == 0) begin
                    // idle burst of random length, this request slot included
                    gap_left = $urandom_range(1, 3) - 1;
                    i_in_valid <= 1'b0;
                end else if (byte_backlog.size() > 0) begin
                    i_rx_byte  <= byte_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            drain_phase <= (byte_backlog.size() < 250);
        end
    end

    // receiver: random short stalls plus one long hold-off to back the parser up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (rx_calm_left > 0)
                rx_calm_left--;
            else if ($urandom_range(0, 63) == 0)
                rx_calm_left = $urandom_range(20, 60);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!hold_done && readings_seen >= 25) begin
                // long hold: the result register fills and footer requests stall
                hold_done = 1'b1;
                hold_left = 300;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!drain_phase && rx_calm_left == 0 && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // checker: every accepted reading against the oldest one owed
    always @(posedge i_clk) begin : reading_check
        t_line_reading got;
        t_line_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.on_line      = o_on_line;
            got.sensor_bits  = o_sensor_bits;
            got.angle_tenths = o_angle_tenths;
            got.confidence   = o_confidence;
            got.side_back    = o_side_back;
            got.side_left    = o_side_left;
            got.side_front   = o_side_front;
            got.side_right   = o_side_right;
            readings_seen <= readings_seen + 1;
            if (readings_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("[%0t] unexpected reading: %s", $realtime, fmt_reading(got));
            end else begin
                want = readings_due.pop_front();
                if (got.on_line !== want.on_line || got.sensor_bits !== want.sensor_bits ||
                    got.angle_tenths !== want.angle_tenths ||
                    got.confidence !== want.confidence || got.side_back !== want.side_back ||
                    got.side_left !== want.side_left || got.side_front !== want.side_front ||
                    got.side_right !== want.side_right) begin
                    faults++;
                    if (faults <= 10)
                        $display("[%0t] reading mismatch\n  expected %s\n  actual   %s",
                                 $realtime, fmt_reading(want), fmt_reading(got));
                end
            end
        end
    end

endmodule
